// ----- design/lcdnib_pkg.sv -----
// Shared types, codes and sequence tables for the character LCD nibble write sequencer.
`default_nettype none

package lcdnib_pkg;

	// Request codes on the input tuser
	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_CMD   = 2'd1,
		MODE_DATA  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic {
		KIND_INIT = 1'b0,
		KIND_BYTE = 1'b1
	} kind_t;

	// Register map
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_PULSE = 1'b0; // word index of enable_pulse_us

	localparam int PULSE_W = 10;
	localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd500;

	localparam int HOLD_W  = 16;
	localparam int EXTRA_W = 13;
	localparam int IDX_W   = 5;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [HOLD_W-1:0]  INIT_WAIT_US  = 16'd40000;
	localparam logic [EXTRA_W-1:0] CLEAR_WAIT_US = 13'd2000;
	localparam logic [7:0]         CMD_CLEAR     = 8'h01;
	localparam logic [IDX_W-1:0]   INIT_LAST_IDX = 5'd24;
	localparam logic [IDX_W-1:0]   INIT_BYTE_IDX = 5'd9;

	// Classified request as it sits in the queue
	typedef struct packed {
		kind_t      kind;
		logic       rs;
		logic [7:0] byte_val;
		logic       clr;
	} req_t;

	// Queue handshake from the front
	typedef struct packed {
		logic valid;
		req_t req;
	} push_t;

	// One step of an event run, before the pulse width is added
	typedef struct packed {
		logic               idle;
		logic               en;
		logic [3:0]         nib;
		logic [EXTRA_W-1:0] extra;
	} step_t;

	function automatic logic [EXTRA_W-1:0] wake_delay(input logic [1:0] i);
		logic [EXTRA_W-1:0] d;
		unique case (i)
			2'd0:    d = 13'd6000;
			2'd1:    d = 13'd300;
			default: d = 13'd2000;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [1:0] i);
		logic [7:0] c;
		unique case (i)
			2'd0:    c = 8'h28;
			2'd1:    c = 8'h0C;
			2'd2:    c = 8'h01;
			default: c = 8'h06;
		endcase
		return c;
	endfunction

	// Event idx of a byte run: high nibble first, enable high then low
	function automatic step_t byte_step(input logic [7:0] b, input logic [1:0] idx,
			input logic [EXTRA_W-1:0] tail);
		step_t s;
		s.idle  = 1'b0;
		s.en    = ~idx[0];
		s.nib   = idx[1] ? b[3:0] : b[7:4];
		s.extra = (idx == 2'd3) ? tail : '0;
		return s;
	endfunction

	function automatic step_t init_step(input logic [IDX_W-1:0] idx);
		step_t s;
		logic [IDX_W-1:0] p;
		logic [IDX_W-1:0] q;
		p = idx - 5'd1;
		q = idx - INIT_BYTE_IDX;
		s = '0;
		if (idx == '0) begin
			s.idle = 1'b1;
		end else if (idx < INIT_BYTE_IDX) begin
			s.en    = ~p[0];
			s.nib   = (p[2:1] == 2'd3) ? 4'h2 : 4'h3;
			s.extra = p[0] ? wake_delay(p[2:1]) : '0;
		end else begin
			s = byte_step(init_cmd(q[3:2]), q[1:0], '0);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- design/lcdnib_front.sv -----
// Request front end: takes input beats and classifies them into queue entries.
`default_nettype none

module lcdnib_front
	import lcdnib_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] in_mode,
	input  wire logic [7:0] in_value,
	input  wire logic       q_full,
	output push_t           push
);

	req_t req;

	always_comb begin
		req = '0;
		unique case (mode_t'(in_mode))
			MODE_INIT: begin
				req.kind = KIND_INIT;
			end
			MODE_CMD: begin
				req.kind     = KIND_BYTE;
				req.byte_val = in_value;
			end
			MODE_DATA: begin
				req.kind     = KIND_BYTE;
				req.rs       = 1'b1;
				req.byte_val = in_value;
			end
			MODE_CLEAR: begin
				req.kind     = KIND_BYTE;
				req.byte_val = CMD_CLEAR;
				req.clr      = 1'b1;
			end
			default: begin
				req.kind = KIND_INIT;
			end
		endcase
	end

	assign in_ready   = ~q_full;
	assign push.valid = in_valid & ~q_full;
	assign push.req   = req;

endmodule

`default_nettype wire

// ----- design/lcdnib_queue.sv -----
// Short request queue between the front end and the event generator.
`default_nettype none

module lcdnib_queue
	import lcdnib_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       full,
	output logic       empty,
	input  wire logic  pop,
	output req_t       head
);

	req_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.valid & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push.req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/lcdnib_back.sv -----
// Event generator: walks the run of the queue head and registers one pin event per beat.
`default_nettype none

module lcdnib_back
	import lcdnib_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [PULSE_W-1:0] pulse_us,
	input  wire req_t               head,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_rs,
	output logic                    out_en,
	output logic [3:0]              out_nib,
	output logic [HOLD_W-1:0]       out_hold,
	output logic                    out_last
);

	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic              rs_q;
	logic              en_q;
	logic [3:0]        nib_q;
	logic [HOLD_W-1:0] hold_q;
	logic              last_q;

	step_t             st;
	logic              ev_last;
	logic [HOLD_W-1:0] ev_hold;
	logic              load;

	always_comb begin
		if (head.kind == KIND_INIT) begin
			st      = init_step(idx_q);
			ev_last = (idx_q == INIT_LAST_IDX);
		end else begin
			st      = byte_step(head.byte_val, idx_q[1:0], head.clr ? CLEAR_WAIT_US : '0);
			ev_last = (idx_q[1:0] == 2'd3);
		end
		ev_hold = st.idle ? INIT_WAIT_US
			: HOLD_W'(pulse_us) + HOLD_W'(st.extra);
	end

	// Advance whenever the queue holds a request and the output register is free or being drained
	assign load = ~empty & (~valid_q | out_ready);
	assign pop  = load & ev_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= ev_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rs_q   <= head.rs;
			en_q   <= st.en;
			nib_q  <= st.nib;
			hold_q <= ev_hold;
			last_q <= ev_last;
		end
	end

	assign out_valid = valid_q;
	assign out_rs    = rs_q;
	assign out_en    = en_q;
	assign out_nib   = nib_q;
	assign out_hold  = hold_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

// ----- design/char_lcd_nibble_write_sequencer_unit.sv -----
// Top level of the character LCD 4-bit write sequencer with its register port.
`default_nettype none

// Turns LCD requests (init, command byte, data byte, clear) into runs of pin
// events for a 4-bit character LCD bus. Each output beat fixes register select
// (tuser), the enable level, the nibble on D7..D4 and the hold time in
// microseconds; tlast marks the final event of a request's run. A byte goes
// out high nibble first, each nibble as an enable-high event then an
// enable-low event, both held enable_pulse_us (APB address 0, reset 500);
// datasheet delays are added to the enable-low hold. Init emits 25 events, the
// other requests 4. Events leave at one per clock while a request is queued
// and the sink takes them: the event generator is the limit. A two-entry
// request queue lets the input side keep accepting while a run is still
// playing out, and the output register loads the next event as the sink
// takes the current one. Write enable_pulse_us only while idle.
module char_lcd_nibble_write_sequencer_unit
	import lcdnib_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // [7:0] value
	input  wire logic [1:0]        s_axis_tuser,  // [1:0] mode
	// pin event stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [23:0]            m_axis_tdata,  // [0] enable, [4:1] nibble, [20:5] hold_us
	output logic                   m_axis_tuser,  // [0] reg_select
	output logic                   m_axis_tlast,
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	logic [PULSE_W-1:0] pulse_q;
	logic               reg_hit;

	push_t push;
	req_t  head;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;

	logic              ev_en;
	logic [3:0]        ev_nib;
	logic [HOLD_W-1:0] ev_hold;

	// Register port: one register, decoded on the word address
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_PULSE);
	assign prdata  = reg_hit ? APB_DW'(pulse_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= PULSE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			pulse_q <= pwdata[PULSE_W-1:0];
		end
	end

	// Front: classify the request and push it into the queue
	lcdnib_front u_front (
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tuser),
		.in_value (s_axis_tdata),
		.q_full   (q_full),
		.push     (push)
	);

	lcdnib_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (q_pop),
		.head   (head)
	);

	// Back: play out the head request one event per beat
	lcdnib_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pulse_us  (pulse_q),
		.head      (head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rs    (m_axis_tuser),
		.out_en    (ev_en),
		.out_nib   (ev_nib),
		.out_hold  (ev_hold),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, ev_hold, ev_nib, ev_en};

endmodule

`default_nettype wire

// ----- tb/tb_char_lcd_nibble_write_sequencer_unit.sv -----
// Self-checking testbench for the character LCD 4-bit write sequencer.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer_unit;
	import lcdnib_pkg::*;

	// Register select levels on the pin event stream
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// Byte address of enable_pulse_us on the register port
	localparam logic [APB_AW-1:0] PULSE_ADDR = APB_AW'(int'(REG_PULSE) * 4);

	// Cycles to wait for outstanding pin events before calling them lost
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 20;

	// One expected pin event, as the sink should see it
	typedef struct packed {
		logic              rs;
		logic              en;
		logic [3:0]        nib;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // [7:0] value
	logic [1:0]        s_axis_tuser = '0;   // [1:0] mode
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;        // [0] enable, [4:1] nibble, [20:5] hold_us
	logic              m_axis_tuser;        // [0] reg_select
	logic              m_axis_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Local copy of the pulse register and the events still owed by the block
	logic [PULSE_W-1:0] pulse_us = PULSE_RESET;
	pin_event_t         pin_events_due[$];
	int                 mismatch_count = 0;
	bit                 calm_pace = 1'b0;   // when set, neither side idles
	int                 sink_stall = 0;
	pin_event_t         want;

	char_lcd_nibble_write_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// Print one mismatch line and count it
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] expd);
		$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, expd);
		mismatch_count++;
	endtask

	// Idle length: mostly none or short, now and then a long stretch
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_pace || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------------
	// Pin event predictor
	// ---------------------------------------------------------------------

	task automatic queue_event(logic rs, logic en, logic [3:0] nib, logic [HOLD_W-1:0] hold);
		pin_event_t ev;
		ev.rs   = rs;
		ev.en   = en;
		ev.nib  = nib;
		ev.hold = hold;
		ev.last = 1'b0;
		pin_events_due.push_back(ev);
	endtask

	// One enable pulse: high, then low; any settle delay rides on the low half
	task automatic queue_nibble(logic rs, logic [3:0] nib, int unsigned extra);
		queue_event(rs, 1'b1, nib, HOLD_W'(pulse_us));
		queue_event(rs, 1'b0, nib, HOLD_W'(pulse_us + extra));
	endtask

	// Byte goes out high nibble first
	task automatic queue_byte(logic rs, logic [7:0] b, int unsigned extra);
		queue_nibble(rs, b[7:4], 0);
		queue_nibble(rs, b[3:0], extra);
	endtask

	task automatic predict_pin_run(mode_t mode, logic [7:0] value);
		case (mode)
			MODE_INIT: begin
				// Power-on wait, the three wake-up nibbles, the switch to 4-bit
				queue_event(RS_CMD, 1'b0, 4'h0, INIT_WAIT_US);
				queue_nibble(RS_CMD, 4'h3, 6000);
				queue_nibble(RS_CMD, 4'h3, 300);
				queue_nibble(RS_CMD, 4'h3, 2000);
				queue_nibble(RS_CMD, 4'h2, 2000);
				// Function set, display on, clear, entry mode
				queue_byte(RS_CMD, 8'h28, 0);
				queue_byte(RS_CMD, 8'h0C, 0);
				queue_byte(RS_CMD, 8'h01, 0);
				queue_byte(RS_CMD, 8'h06, 0);
			end
			MODE_CMD:  queue_byte(RS_CMD, value, 0);
			MODE_DATA: queue_byte(RS_DATA, value, 0);
			default:   queue_byte(RS_CMD, CMD_CLEAR, CLEAR_WAIT_US);
		endcase
		pin_events_due[pin_events_due.size() - 1].last = 1'b1;
	endtask

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------

	// Send one request beat and queue its pin run once it is taken.
	// Valid stays high after the beat; a later gap or drain drops it.
	task automatic send_request(mode_t mode, logic [7:0] value);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		predict_pin_run(mode, value);
	endtask

	task automatic send_random_request();
		int   r;
		mode_t mode;
		r = $urandom_range(0, 99);
		// Init runs are long, so keep them to a small share of the traffic
		if (r < 10)      mode = MODE_INIT;
		else if (r < 40) mode = MODE_CMD;
		else if (r < 75) mode = MODE_DATA;
		else             mode = MODE_CLEAR;
		send_request(mode, 8'($urandom_range(0, 255)));
	endtask

	// Drop valid and wait until every owed pin event has come out
	task automatic wait_for_pin_events();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (pin_events_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pin_events_due.size() != 0) begin
			report_mismatch("pin events never delivered", pin_events_due.size(), 0);
			pin_events_due.delete();
		end
	endtask

	// ---------------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------------

	// Setup cycle, then access; the write lands on the access edge
	task automatic write_pulse_reg(logic [APB_DW-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PULSE_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pulse_us = word[PULSE_W-1:0];
	endtask

	task automatic check_pulse_reg();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PULSE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(pulse_us))
			report_mismatch("enable_pulse_us readback", prdata, APB_DW'(pulse_us));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change the pulse width only once the block has gone quiet
	task automatic retune_pulse(logic [APB_DW-1:0] word);
		wait_for_pin_events();
		repeat (4) @(posedge clk);
		write_pulse_reg(word);
		check_pulse_reg();
	endtask

	// ---------------------------------------------------------------------
	// Pin event side: random backpressure and the checker
	// ---------------------------------------------------------------------

	// Hold ready low for a random stall now and then; none while calm
	always @(posedge clk) begin
		if (sink_stall > 0)
			sink_stall--;
		else if (!calm_pace && $urandom_range(0, 99) < 40)
			sink_stall = idle_gap();
		m_axis_tready <= (sink_stall == 0);
	end

	// Compare every delivered beat against the oldest owed event
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pin_events_due.size() == 0) begin
				report_mismatch("unexpected pin event", m_axis_tdata, 0);
			end else begin
				want = pin_events_due.pop_front();
				if (m_axis_tuser !== want.rs)
					report_mismatch("reg_select", m_axis_tuser, want.rs);
				if (m_axis_tdata[0] !== want.en)
					report_mismatch("enable", m_axis_tdata[0], want.en);
				if (m_axis_tdata[4:1] !== want.nib)
					report_mismatch("nibble", m_axis_tdata[4:1], want.nib);
				if (m_axis_tdata[20:5] !== want.hold)
					report_mismatch("hold_us", m_axis_tdata[20:5], want.hold);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
				if (m_axis_tdata[23:21] !== 3'b000)
					report_mismatch("tdata padding", m_axis_tdata[23:21], 0);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset value reads back; a write with junk above bit 9 keeps only the low bits
	task automatic test_register_access();
		check_pulse_reg();
		write_pulse_reg(32'hFFFF_FC00 | 32'd123);
		check_pulse_reg();
		write_pulse_reg(APB_DW'(PULSE_RESET));
		check_pulse_reg();
	endtask

	// Every mode at the reset pulse width, with byte extremes and ignored values
	task automatic test_directed_modes();
		send_request(MODE_INIT, 8'h00);
		send_request(MODE_CMD, 8'h00);
		send_request(MODE_CMD, 8'hFF);
		send_request(MODE_DATA, 8'h00);
		send_request(MODE_DATA, 8'hFF);
		send_request(MODE_DATA, 8'hA5);
		send_request(MODE_CLEAR, 8'hFF);
		send_request(MODE_INIT, 8'hFF);
		send_request(MODE_CMD, 8'h5A);
	endtask

	// Pulse widths of 1, 1000, zero and an out-of-range word on each kind of run
	task automatic test_pulse_extremes();
		logic [APB_DW-1:0] words[4];
		words = '{32'd1, 32'd1000, 32'd0, 32'hFFFF_FFFF};
		foreach (words[i]) begin
			retune_pulse(words[i]);
			send_request(MODE_INIT, 8'($urandom_range(0, 255)));
			send_request(MODE_CLEAR, 8'($urandom_range(0, 255)));
			send_request(MODE_DATA, 8'($urandom_range(0, 255)));
			send_request(MODE_CMD, 8'($urandom_range(0, 255)));
		end
	endtask

	// Mixed traffic over several pulse widths and pacing styles
	task automatic test_random_traffic();
		logic [APB_DW-1:0] word;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       word = 32'd1;
				1:       word = 32'd1000;
				2:       word = $urandom_range(1, 1000);
				3:       word = 32'd0;
				4:       word = $urandom() | 32'h3FF;
				5:       word = $urandom_range(0, 1023);
				default: word = APB_DW'(PULSE_RESET);
			endcase
			retune_pulse(word);
			calm_pace = (phase % 3 == 1);
			for (int n = 0; n < 55; n++) begin
				// Once, hold off mid-phase until the block has caught up
				if (phase == 2 && n == 27)
					wait_for_pin_events();
				send_random_request();
			end
		end
		calm_pace = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed_modes();
		test_pulse_extremes();
		test_random_traffic();

		// Let the last runs finish, then watch for stray beats
		wait_for_pin_events();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#30_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
